/* design/gdda_pkg.sv */
// shared widths, calendar constants and the month start table for the date arithmetic block
`default_nettype none

package gdda_pkg;

   localparam int DAY_W     = 5;
   localparam int MONTH_W   = 4;
   localparam int YEAR_W    = 14;
   localparam int OFFSET_W  = 23;
   localparam int DSERIAL_W = 22;
   localparam int SERIAL_W  = 24;
   localparam int TARGET_W  = 25;
   localparam int MSTART_W  = 9;

   localparam int SER_LAT   = 3;
   localparam int SPLIT_LAT = 8;

   localparam logic [17:0] DAYS_400Y = 18'd146097;
   localparam logic [15:0] DAYS_100Y = 16'd36524;
   localparam logic [10:0] DAYS_4Y   = 11'd1461;
   localparam logic [8:0]  DAYS_1Y   = 9'd365;
   localparam logic [4:0]  QUAD_LAST = 5'd24;

   localparam logic [12:0] RECIP25 = 13'd5243;
   localparam int          SHIFT25 = 17;

   localparam logic signed [SERIAL_W-1:0] DBY_YEAR0 = -24'sd366;

   function automatic logic [MSTART_W-1:0] month_start(input logic leap,
                                                       input logic [MONTH_W-1:0] m);
      logic [MSTART_W-1:0] base;
      case (m)
         4'd0:    base = 9'd0;
         4'd1:    base = 9'd0;
         4'd2:    base = 9'd31;
         4'd3:    base = 9'd59;
         4'd4:    base = 9'd90;
         4'd5:    base = 9'd120;
         4'd6:    base = 9'd151;
         4'd7:    base = 9'd181;
         4'd8:    base = 9'd212;
         4'd9:    base = 9'd243;
         4'd10:   base = 9'd273;
         4'd11:   base = 9'd304;
         4'd12:   base = 9'd334;
         default: base = 9'd365;
      endcase
      return base + {8'd0, leap && (m >= 4'd3)};
   endfunction

endpackage

`default_nettype wire

/* design/gdda_to_serial.sv */
// date to serial day number, three register stages
`default_nettype none

module gdda_to_serial import gdda_pkg::*; (
   input  logic                       clock,
   input  logic [YEAR_W-1:0]          year,
   input  logic [MONTH_W-1:0]         month,
   input  logic [DAY_W-1:0]           day,
   output logic signed [SERIAL_W-1:0] serial
);

   logic [YEAR_W-1:0] p_in;
   logic [22:0]       p365_in;
   logic [24:0]       pq100_prod;
   logic [22:0]       pq400_prod;
   logic [24:0]       yq100_prod;
   logic [22:0]       yq400_prod;

   logic              b_zero_ff;
   logic [YEAR_W-1:0] b_p_ff;
   logic [22:0]       b_p365_ff;
   logic [7:0]        b_pq100_ff;
   logic [5:0]        b_pq400_ff;
   logic [7:0]        b_yq100_ff;
   logic [5:0]        b_yq400_ff;
   logic [YEAR_W-1:0] b_year_ff;
   logic [MONTH_W-1:0] b_month_ff;
   logic [DAY_W-1:0]  b_day_ff;

   logic                       div100;
   logic                       div400;
   logic                       leap;
   logic [SERIAL_W-1:0]        dby_sum;
   logic signed [SERIAL_W-1:0] c_dby_in;
   logic [MSTART_W-1:0]        c_msd_in;
   logic signed [SERIAL_W-1:0] c_dby_ff;
   logic [MSTART_W-1:0]        c_msd_ff;

   logic signed [SERIAL_W-1:0] serial_in;
   logic signed [SERIAL_W-1:0] serial_ff;

   // stage b: leap counts by reciprocal multiply
   assign p_in       = year - 14'd1;
   assign p365_in    = 23'(p_in) * 23'd365;
   assign pq100_prod = 25'(p_in[13:2]) * 25'(RECIP25);
   assign pq400_prod = 23'(p_in[13:4]) * 23'(RECIP25);
   assign yq100_prod = 25'(year[13:2]) * 25'(RECIP25);
   assign yq400_prod = 23'(year[13:4]) * 23'(RECIP25);

   always_ff @(posedge clock) begin
      b_zero_ff  <= (year == '0);
      b_p_ff     <= p_in;
      b_p365_ff  <= p365_in;
      b_pq100_ff <= pq100_prod[24:SHIFT25];
      b_pq400_ff <= pq400_prod[22:SHIFT25];
      b_yq100_ff <= yq100_prod[24:SHIFT25];
      b_yq400_ff <= yq400_prod[22:SHIFT25];
      b_year_ff  <= year;
      b_month_ff <= month;
      b_day_ff   <= day;
   end

   // stage c: days before the year, day within the year
   assign div100  = (b_year_ff[1:0] == 2'd0) &&
                    (b_year_ff[13:2] == 12'(12'(b_yq100_ff) * 12'd25));
   assign div400  = (b_year_ff[3:0] == 4'd0) &&
                    (b_year_ff[13:4] == 10'(10'(b_yq400_ff) * 10'd25));
   assign leap    = ((b_year_ff[1:0] == 2'd0) && !div100) || div400;
   assign dby_sum = 24'(b_p365_ff) + 24'(b_p_ff[13:2]) - 24'(b_pq100_ff)
                    + 24'(b_pq400_ff);
   assign c_dby_in = b_zero_ff ? DBY_YEAR0 : $signed(dby_sum);
   assign c_msd_in = month_start(leap, b_month_ff) + 9'(b_day_ff);

   always_ff @(posedge clock) begin
      c_dby_ff <= c_dby_in;
      c_msd_ff <= c_msd_in;
   end

   // stage d
   assign serial_in = c_dby_ff + $signed({15'd0, c_msd_ff});

   always_ff @(posedge clock) begin
      serial_ff <= serial_in;
   end

   assign serial = serial_ff;

endmodule

`default_nettype wire

/* design/gdda_from_serial.sv */
// zero-based day number to day, month and year, eight register stages
`default_nettype none

module gdda_from_serial import gdda_pkg::*; (
   input  logic                 clock,
   input  logic [DSERIAL_W-1:0] n,
   output logic [DAY_W-1:0]     day,
   output logic [MONTH_W-1:0]   month,
   output logic [YEAR_W-1:0]    year
);

   localparam int          S400      = 40;
   localparam int          S4        = 27;
   localparam logic [63:0] K400_WIDE = ((64'd1 << S400) + 64'd146096) / 64'd146097;
   localparam logic [63:0] K4_WIDE   = ((64'd1 << S4) + 64'd1460) / 64'd1461;
   localparam logic [22:0] K400      = K400_WIDE[22:0];
   localparam logic [16:0] K4        = K4_WIDE[16:0];

   logic [44:0]          f_prod;
   logic [4:0]           f_q_ff;
   logic [DSERIAL_W-1:0] f_n_ff;

   logic [17:0] g_r_in;
   logic [17:0] g_r_ff;
   logic [4:0]  g_q_ff;

   logic [1:0]  h_c_in;
   logic [15:0] h_r2_in;
   logic [1:0]  h_c_ff;
   logic [15:0] h_r2_ff;
   logic [4:0]  h_q_ff;

   logic [32:0] i_prod;
   logic [4:0]  i_q4_ff;
   logic [15:0] i_r2_ff;
   logic [1:0]  i_c_ff;
   logic [4:0]  i_q_ff;

   logic [10:0] j_r3_in;
   logic [10:0] j_r3_ff;
   logic [4:0]  j_q4_ff;
   logic [1:0]  j_c_ff;
   logic [4:0]  j_q_ff;

   logic [1:0]        y1;
   logic [8:0]        k_r4_in;
   logic              k_leap_in;
   logic [YEAR_W-1:0] k_yr_in;
   logic [8:0]        k_r4_ff;
   logic              k_leap_ff;
   logic [YEAR_W-1:0] k_yr_ff;

   logic [MONTH_W-1:0] l_mo_in;
   logic [MONTH_W-1:0] l_mo_ff;
   logic [8:0]         l_r4_ff;
   logic               l_leap_ff;
   logic [YEAR_W-1:0]  l_yr_ff;

   logic [DAY_W-1:0]   m_day_in;
   logic [DAY_W-1:0]   m_day_ff;
   logic [MONTH_W-1:0] m_month_ff;
   logic [YEAR_W-1:0]  m_year_ff;

   // stage f: 400-year cycles
   assign f_prod = 45'(n) * 45'(K400);

   always_ff @(posedge clock) begin
      f_q_ff <= f_prod[44:S400];
      f_n_ff <= n;
   end

   // stage g
   assign g_r_in = 18'(f_n_ff - 22'(22'(f_q_ff) * 22'(DAYS_400Y)));

   always_ff @(posedge clock) begin
      g_r_ff <= g_r_in;
      g_q_ff <= f_q_ff;
   end

   // stage h: centuries, last one holds the extra day
   assign h_c_in  = {1'b0, g_r_ff >= 18'(DAYS_100Y)}
                    + {1'b0, g_r_ff >= 18'(18'd2 * 18'(DAYS_100Y))}
                    + {1'b0, g_r_ff >= 18'(18'd3 * 18'(DAYS_100Y))};
   assign h_r2_in = 16'(g_r_ff - 18'(18'(h_c_in) * 18'(DAYS_100Y)));

   always_ff @(posedge clock) begin
      h_c_ff  <= h_c_in;
      h_r2_ff <= h_r2_in;
      h_q_ff  <= g_q_ff;
   end

   // stage i: four-year groups
   assign i_prod = 33'(h_r2_ff) * 33'(K4);

   always_ff @(posedge clock) begin
      i_q4_ff <= i_prod[31:S4];
      i_r2_ff <= h_r2_ff;
      i_c_ff  <= h_c_ff;
      i_q_ff  <= h_q_ff;
   end

   // stage j
   assign j_r3_in = 11'(i_r2_ff - 16'(16'(i_q4_ff) * 16'(DAYS_4Y)));

   always_ff @(posedge clock) begin
      j_r3_ff <= j_r3_in;
      j_q4_ff <= i_q4_ff;
      j_c_ff  <= i_c_ff;
      j_q_ff  <= i_q_ff;
   end

   // stage k: single years, leap follows from the cycle position
   assign y1 = {1'b0, j_r3_ff >= 11'(DAYS_1Y)}
               + {1'b0, j_r3_ff >= 11'(11'd2 * 11'(DAYS_1Y))}
               + {1'b0, j_r3_ff >= 11'(11'd3 * 11'(DAYS_1Y))};
   assign k_r4_in   = 9'(j_r3_ff - 11'(11'(y1) * 11'(DAYS_1Y)));
   assign k_leap_in = (y1 == 2'd3) && ((j_q4_ff != QUAD_LAST) || (j_c_ff == 2'd3));
   assign k_yr_in   = 14'(j_q_ff) * 14'd400 + 14'(j_c_ff) * 14'd100
                      + 14'(j_q4_ff) * 14'd4 + 14'(y1) + 14'd1;

   always_ff @(posedge clock) begin
      k_r4_ff   <= k_r4_in;
      k_leap_ff <= k_leap_in;
      k_yr_ff   <= k_yr_in;
   end

   // stage l: month search
   always_comb begin
      l_mo_in = 4'd1;
      for (int k = 2; k <= 12; k++) begin
         l_mo_in = l_mo_in + {3'd0, k_r4_ff >= month_start(k_leap_ff, 4'(k))};
      end
   end

   always_ff @(posedge clock) begin
      l_mo_ff   <= l_mo_in;
      l_r4_ff   <= k_r4_ff;
      l_leap_ff <= k_leap_ff;
      l_yr_ff   <= k_yr_ff;
   end

   // stage m
   assign m_day_in = 5'(l_r4_ff - month_start(l_leap_ff, l_mo_ff) + 9'd1);

   always_ff @(posedge clock) begin
      m_day_ff   <= m_day_in;
      m_month_ff <= l_mo_ff;
      m_year_ff  <= l_yr_ff;
   end

   assign day   = m_day_ff;
   assign month = m_month_ff;
   assign year  = m_year_ff;

endmodule

`default_nettype wire

/* design/gregorian_date_day_arithmetic.sv */
// top level: gregorian date to serial day number and date shift by a day offset
//
//   channel   ports                                              handshake
//   request   req_in_day, req_in_month, req_in_year,             start, busy
//             req_day_offset
//   response  rsp_day_serial, rsp_out_day, rsp_out_month,        rsp_valid strobe
//             rsp_out_year, rsp_range_error
//
// one transaction per cycle, busy stays low
// rsp_valid rises together with the result register: the input register loads at the
// accepting edge, then three serial stages, the range stage, eight split stages and
// the result register follow
// synchronous reset clears the valid pipeline only
// rsp_valid is a single-cycle strobe; the receiver cannot stall
`default_nettype none

module gregorian_date_day_arithmetic import gdda_pkg::*; #(
   parameter int MAX_YEAR = 9999
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [DAY_W-1:0]            req_in_day,
   input  logic [MONTH_W-1:0]          req_in_month,
   input  logic [YEAR_W-1:0]           req_in_year,
   input  logic signed [OFFSET_W-1:0]  req_day_offset,
   output logic                        rsp_valid,
   output logic [DSERIAL_W-1:0]        rsp_day_serial,
   output logic [DAY_W-1:0]            rsp_out_day,
   output logic [MONTH_W-1:0]          rsp_out_month,
   output logic [YEAR_W-1:0]           rsp_out_year,
   output logic                        rsp_range_error
);

   localparam logic signed [TARGET_W-1:0] LAST_DAY =
      TARGET_W'(365 * MAX_YEAR + MAX_YEAR / 4 - MAX_YEAR / 100 + MAX_YEAR / 400);
   localparam int VLD_LEN = SER_LAT + SPLIT_LAT + 3;

   typedef struct packed {
      logic                 err;
      logic [DSERIAL_W-1:0] serial;
   } tag_type;

   logic                 accept;
   logic [VLD_LEN-1:0]   vld_in;
   logic [VLD_LEN-1:0]   vld_ff;

   logic [DAY_W-1:0]           a_day_ff;
   logic [MONTH_W-1:0]         a_month_ff;
   logic [YEAR_W-1:0]          a_year_ff;
   logic signed [OFFSET_W-1:0] a_off_ff;

   logic signed [OFFSET_W-1:0] off_line_ff [SER_LAT];
   logic signed [SERIAL_W-1:0] serial;

   logic signed [TARGET_W-1:0] target;
   logic                       e_err_in;
   logic [DSERIAL_W-1:0]       e_n_in;
   logic [DSERIAL_W-1:0]       e_n_ff;
   tag_type                    e_tag_ff;

   tag_type                    tag_ff [SPLIT_LAT];

   logic [DAY_W-1:0]   split_day;
   logic [MONTH_W-1:0] split_month;
   logic [YEAR_W-1:0]  split_year;

   logic [DSERIAL_W-1:0] rsp_serial_ff;
   logic [DAY_W-1:0]     rsp_day_ff;
   logic [MONTH_W-1:0]   rsp_month_ff;
   logic [YEAR_W-1:0]    rsp_year_ff;
   logic                 rsp_err_ff;

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign vld_in = {vld_ff[VLD_LEN-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_day_ff   <= req_in_day;
         a_month_ff <= req_in_month;
         a_year_ff  <= req_in_year;
         a_off_ff   <= req_day_offset;
      end
   end

   gdda_to_serial u_to_serial (
      .clock  (clock),
      .year   (a_year_ff),
      .month  (a_month_ff),
      .day    (a_day_ff),
      .serial (serial)
   );

   // offset travels alongside the serial stages
   always_ff @(posedge clock) begin
      off_line_ff[0] <= a_off_ff;
      for (int k = 1; k < SER_LAT; k++) begin
         off_line_ff[k] <= off_line_ff[k-1];
      end
   end

   // range stage
   assign target   = TARGET_W'(serial) + TARGET_W'(off_line_ff[SER_LAT-1]);
   assign e_err_in = (target < 25'sd1) || (target > LAST_DAY);
   assign e_n_in   = DSERIAL_W'(target - 25'sd1);

   always_ff @(posedge clock) begin
      e_n_ff          <= e_n_in;
      e_tag_ff.err    <= e_err_in;
      e_tag_ff.serial <= DSERIAL_W'(serial);
   end

   gdda_from_serial u_from_serial (
      .clock (clock),
      .n     (e_n_ff),
      .day   (split_day),
      .month (split_month),
      .year  (split_year)
   );

   always_ff @(posedge clock) begin
      tag_ff[0] <= e_tag_ff;
      for (int k = 1; k < SPLIT_LAT; k++) begin
         tag_ff[k] <= tag_ff[k-1];
      end
   end

   // result register, date fields read zero on range error
   always_ff @(posedge clock) begin
      rsp_serial_ff <= tag_ff[SPLIT_LAT-1].serial;
      rsp_err_ff    <= tag_ff[SPLIT_LAT-1].err;
      rsp_day_ff    <= tag_ff[SPLIT_LAT-1].err ? '0 : split_day;
      rsp_month_ff  <= tag_ff[SPLIT_LAT-1].err ? '0 : split_month;
      rsp_year_ff   <= tag_ff[SPLIT_LAT-1].err ? '0 : split_year;
   end

   assign rsp_valid       = vld_ff[VLD_LEN-1];
   assign rsp_day_serial  = rsp_serial_ff;
   assign rsp_out_day     = rsp_day_ff;
   assign rsp_out_month   = rsp_month_ff;
   assign rsp_out_year    = rsp_year_ff;
   assign rsp_range_error = rsp_err_ff;

endmodule

`default_nettype wire
